// File: design/qsv_pkg.sv
// Shared types, codes, gate matrices and rounding helpers for the
// state-vector gate engine. No dependencies.
`default_nettype none
package qsv_pkg;

  localparam logic [1:0] CMD_G1  = 2'd0;
  localparam logic [1:0] CMD_G2  = 2'd1;
  localparam logic [1:0] CMD_RD  = 2'd2;
  localparam logic [1:0] CMD_RST = 2'd3;

  localparam logic [3:0] G2_CNOT = 4'd0;
  localparam logic [3:0] G2_CZ   = 4'd1;
  localparam logic [3:0] G2_SWAP = 4'd2;

  localparam logic signed [15:0] P1 = 16'sd16384;
  localparam logic signed [15:0] N1 = -16'sd16384;
  localparam logic signed [15:0] PR = 16'sd11585;
  localparam logic signed [15:0] NR = -16'sd11585;
  localparam logic signed [15:0] PH = 16'sd8192;
  localparam logic signed [15:0] NH = -16'sd8192;
  localparam logic signed [15:0] ZR = 16'sd0;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } cplx_t;

  // entry index is row * 2 + column
  typedef cplx_t [3:0] mat_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] gate;
    logic [3:0] qa;
    logic [3:0] qb;
    logic [9:0] amp_index;
  } op_t;

  typedef struct packed {
    logic       rd_en;
    logic       rd_hi;
    logic       rd_amp;
    logic       wr_en;
    logic       wr_hi;
    logic       clr;
    logic       lat0;
    logic       lat1;
    logic       acc_clr;
    logic       mac_en;
    logic [1:0] mac_k;
    logic       acc_en;
    logic [1:0] acc_k;
    logic       out_ld;
    logic       out_rd;
    logic       out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
  } dp_stat_t;

  function automatic mat_t gate1_mat(input logic [3:0] g);
    mat_t m;
    case (g)
      4'd0:  m = {{P1, ZR}, {ZR, ZR}, {ZR, ZR}, {P1, ZR}};
      4'd1:  m = {{ZR, ZR}, {P1, ZR}, {P1, ZR}, {ZR, ZR}};
      4'd2:  m = {{ZR, ZR}, {ZR, P1}, {ZR, N1}, {ZR, ZR}};
      4'd3:  m = {{N1, ZR}, {ZR, ZR}, {ZR, ZR}, {P1, ZR}};
      4'd4:  m = {{NR, ZR}, {PR, ZR}, {PR, ZR}, {PR, ZR}};
      4'd5:  m = {{ZR, ZR}, {PR, PR}, {PR, NR}, {ZR, ZR}};
      4'd6:  m = {{NR, ZR}, {PR, ZR}, {PR, ZR}, {PR, ZR}};
      4'd7:  m = {{NR, ZR}, {ZR, PR}, {ZR, NR}, {PR, ZR}};
      4'd8:  m = {{PH, PH}, {PH, NH}, {PH, NH}, {PH, PH}};
      4'd9:  m = {{PH, NH}, {PH, PH}, {PH, PH}, {PH, NH}};
      4'd10: m = {{PH, PH}, {PH, PH}, {NH, NH}, {PH, PH}};
      4'd11: m = {{PH, NH}, {NH, PH}, {PH, NH}, {PH, NH}};
      4'd12, 4'd14: m = {{ZR, P1}, {ZR, ZR}, {ZR, ZR}, {P1, ZR}};
      default: m = {{ZR, N1}, {ZR, ZR}, {ZR, ZR}, {P1, ZR}};
    endcase
    return m;
  endfunction

  // Q8.28 sum to Q2.14: nearest, ties away from zero, saturated
  function automatic logic signed [15:0] round_q14(input logic signed [35:0] s);
    logic        neg;
    logic [35:0] mag;
    logic [36:0] sum;
    logic [22:0] q;
    logic signed [15:0] r;
    neg = s[35];
    mag = neg ? 36'(-s) : 36'(s);
    sum = {1'b0, mag} + 37'd8192;
    q   = sum[36:14];
    if (!neg && q > 23'd32767) begin
      r = 16'sh7fff;
    end else if (neg && q > 23'd32768) begin
      r = 16'sh8000;
    end else begin
      r = neg ? 16'(-q) : 16'(q);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] x);
    return (x == 16'sh8000) ? 16'sh7fff : -x;
  endfunction

endpackage
`default_nettype wire

// File: design/qsv_if.sv
// Handshake channel interfaces for commands and results.
// Depends on nothing.
`default_nettype none
interface qsv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] gate_code;
  logic [3:0] qubit_a;
  logic [3:0] qubit_b;
  logic [9:0] amp_index;
  modport source (output valid, command, gate_code, qubit_a, qubit_b, amp_index,
                  input ready);
  modport sink (input valid, command, gate_code, qubit_a, qubit_b, amp_index,
                output ready);
endinterface

interface qsv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] amp_real;
  logic signed [15:0] amp_imag;
  logic               error_flag;
  modport source (output valid, amp_real, amp_imag, error_flag, input ready);
  modport sink (input valid, amp_real, amp_imag, error_flag, output ready);
endinterface
`default_nettype wire

// File: design/qsv_datapath.sv
// Amplitude memory, operand latches, complex MAC, rounding and result register.
// Depends on qsv_pkg.
`default_nettype none
module qsv_datapath #(
  parameter int QUBITS = 10
) (
  input  wire logic                 clk,
  input  wire qsv_pkg::dp_cmd_t     cmd,
  input  wire qsv_pkg::op_t         op,
  input  wire logic [QUBITS-1:0]    cnt,
  output qsv_pkg::dp_stat_t         stat,
  output logic signed [15:0]        amp_real,
  output logic signed [15:0]        amp_imag,
  output logic                      error_flag
);
  import qsv_pkg::*;

  localparam int AW    = QUBITS;
  localparam int DEPTH = 1 << AW;

  cplx_t mem [DEPTH];
  cplx_t rdata_r;
  cplx_t x0_r, x1_r;
  logic signed [31:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [35:0] acc_re_r [2];
  logic signed [35:0] acc_im_r [2];
  logic signed [15:0] out_re_r, out_im_r;
  logic               out_err_r;

  logic [AW-1:0]    ba, bb, i0, i1, raddr, waddr, amp_addr;
  logic [AW+9:0]    amp_ext;
  logic             one_q;
  cplx_t            wdata, xs, mc;
  mat_t             mat;

  always_comb begin
    ba      = {{(AW-1){1'b0}}, 1'b1} << op.qa;
    bb      = {{(AW-1){1'b0}}, 1'b1} << op.qb;
    one_q   = (op.cmd == CMD_G1);
    amp_ext = {{AW{1'b0}}, op.amp_index};
    amp_addr = amp_ext[AW-1:0];
    if (one_q) begin
      i0 = cnt;
      i1 = cnt | ba;
      stat.skip = (cnt & ba) != '0;
    end else begin
      stat.skip = (cnt & (ba | bb)) != '0;
      case (op.gate)
        G2_CNOT: begin
          i0 = cnt | ba;
          i1 = cnt | ba | bb;
        end
        G2_CZ: begin
          i0 = cnt | ba | bb;
          i1 = cnt | ba | bb;
        end
        default: begin
          i0 = cnt | ba;
          i1 = cnt | bb;
        end
      endcase
    end
    raddr = cmd.rd_amp ? amp_addr : (cmd.rd_hi ? i1 : i0);
    waddr = cmd.clr ? cnt : (cmd.wr_hi ? i1 : i0);
    if (cmd.clr) begin
      wdata = (cnt == '0) ? {P1, ZR} : {ZR, ZR};
    end else if (one_q) begin
      wdata.re = round_q14(acc_re_r[cmd.wr_hi]);
      wdata.im = round_q14(acc_im_r[cmd.wr_hi]);
    end else if (op.gate == G2_CZ) begin
      wdata.re = neg_sat(x0_r.re);
      wdata.im = neg_sat(x0_r.im);
    end else begin
      wdata = cmd.wr_hi ? x0_r : x1_r;
    end
    mat = gate1_mat(op.gate);
    mc  = mat[cmd.mac_k];
    xs  = cmd.mac_k[0] ? x1_r : x0_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.lat0) x0_r <= rdata_r;
    if (cmd.lat1) x1_r <= rdata_r;
    if (cmd.mac_en) begin
      pa_r <= mc.re * xs.re;
      pb_r <= mc.im * xs.im;
      pc_r <= mc.re * xs.im;
      pd_r <= mc.im * xs.re;
    end
    if (cmd.acc_clr) begin
      acc_re_r[0] <= '0;
      acc_re_r[1] <= '0;
      acc_im_r[0] <= '0;
      acc_im_r[1] <= '0;
    end else if (cmd.acc_en) begin
      acc_re_r[cmd.acc_k[1]] <= acc_re_r[cmd.acc_k[1]] + 36'(pa_r) - 36'(pb_r);
      acc_im_r[cmd.acc_k[1]] <= acc_im_r[cmd.acc_k[1]] + 36'(pc_r) + 36'(pd_r);
    end
    if (cmd.out_ld) begin
      out_re_r  <= cmd.out_rd ? x0_r.re : ZR;
      out_im_r  <= cmd.out_rd ? x0_r.im : ZR;
      out_err_r <= cmd.out_err;
    end
  end

  assign amp_real   = out_re_r;
  assign amp_imag   = out_im_r;
  assign error_flag = out_err_r;

endmodule
`default_nettype wire

// File: design/qsv_ctrl.sv
// Command sequencer: accepts items, sweeps the amplitude memory, issues
// datapath strobes and owns the result valid. Depends on qsv_pkg.
`default_nettype none
module qsv_ctrl #(
  parameter int QUBITS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire qsv_pkg::op_t      in_op,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qsv_pkg::dp_cmd_t       cmd,
  output qsv_pkg::op_t           op,
  output logic [QUBITS-1:0]      cnt,
  input  wire qsv_pkg::dp_stat_t stat
);
  import qsv_pkg::*;

  localparam int AW = QUBITS;
  localparam logic [4:0] QN = 5'(QUBITS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_RD0, S_RD1, S_LAT, S_MAC, S_WR0, S_WR1,
    S_RRD, S_RWT, S_FIN
  } state_t;

  state_t         state_r;
  logic [AW-1:0]  cnt_r;
  logic [2:0]     k_r;
  op_t            op_r;
  logic           err_r;
  logic           clr_reply_r;
  logic           out_valid_r;

  logic        qa_bad, qb_bad, idx_bad, g2_bad, last, take;
  logic [15:0] ai16;

  always_comb begin
    qa_bad  = {1'b0, in_op.qa} >= QN;
    qb_bad  = {1'b0, in_op.qb} >= QN;
    ai16    = {6'd0, in_op.amp_index};
    idx_bad = (ai16 >> AW) != 16'd0;
    g2_bad  = qa_bad || qb_bad || (in_op.qa == in_op.qb) || (in_op.gate > G2_SWAP);
    last    = &cnt_r;
    take    = in_valid && (state_r == S_IDLE);
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLR: begin
        cmd.wr_en = 1'b1;
        cmd.clr   = 1'b1;
      end
      S_RD0: cmd.rd_en = 1'b1;
      S_RD1: begin
        cmd.rd_en = 1'b1;
        cmd.rd_hi = 1'b1;
        cmd.lat0  = 1'b1;
      end
      S_LAT: begin
        cmd.lat1    = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_MAC: begin
        cmd.mac_en = (k_r != 3'd4);
        cmd.mac_k  = k_r[1:0];
        cmd.acc_en = (k_r != 3'd0);
        cmd.acc_k  = 2'(k_r - 3'd1);
      end
      S_WR0: cmd.wr_en = 1'b1;
      S_WR1: begin
        cmd.wr_en = 1'b1;
        cmd.wr_hi = 1'b1;
      end
      S_RRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_amp = 1'b1;
      end
      S_RWT: cmd.lat0 = 1'b1;
      S_FIN: begin
        cmd.out_ld  = !out_valid_r || out_ready;
        cmd.out_rd  = (op_r.cmd == CMD_RD) && !err_r;
        cmd.out_err = err_r;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      k_r         <= '0;
      err_r       <= 1'b0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          if (last) begin
            cnt_r   <= '0;
            state_r <= clr_reply_r ? S_FIN : S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (take) begin
            op_r  <= in_op;
            cnt_r <= '0;
            case (in_op.cmd)
              CMD_G1: begin
                err_r   <= qa_bad;
                state_r <= qa_bad ? S_FIN : S_SCAN;
              end
              CMD_G2: begin
                err_r   <= g2_bad;
                state_r <= g2_bad ? S_FIN : S_SCAN;
              end
              CMD_RD: begin
                err_r   <= idx_bad;
                state_r <= idx_bad ? S_FIN : S_RRD;
              end
              default: begin
                err_r       <= 1'b0;
                clr_reply_r <= 1'b1;
                state_r     <= S_CLR;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!stat.skip) begin
            state_r <= S_RD0;
          end else if (last) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: state_r <= S_LAT;
        S_LAT: begin
          k_r     <= '0;
          state_r <= (op_r.cmd == CMD_G1) ? S_MAC : S_WR0;
        end
        S_MAC: begin
          if (k_r == 3'd4) begin
            state_r <= S_WR0;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_WR0: state_r <= S_WR1;
        S_WR1: begin
          if (last) begin
            state_r <= S_FIN;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_RRD: state_r <= S_RWT;
        S_RWT: state_r <= S_FIN;
        S_FIN: begin
          // hold until the result register is free
          if (!out_valid_r || out_ready) begin
            clr_reply_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign op        = op_r;
  assign cnt       = cnt_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("pending result overwritten");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish");

  a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && k_r == 3'd4) |=> (state_r == S_WR0))
    else $error("MAC sequence overran");

endmodule
`default_nettype wire

// File: design/qubit_state_vector_gate_apply_unit.sv
// State-vector gate engine: keeps 2^QUBITS complex Q2.14 amplitudes in one
// memory and applies one-qubit gates, CNOT/CZ/SWAP, reads and resets.
//
// Channels: in_if carries one command item (command, gate_code, qubit_a,
// qubit_b, amp_index); out_if returns exactly one item per command
// (amp_real, amp_imag, error_flag). Both use valid/ready.
// Items are handled one at a time through the single memory read port and
// write port. Per amplitude pair, a one-qubit gate steps through scan, two
// reads, latch, five MAC steps and two writes; a two-qubit gate steps through
// scan, two reads, latch and two writes; a skipped index takes only the scan
// state. A read goes through a memory read and a latch; a rejected command
// goes straight to the finish state.
// in_ready returns in the same cycle that out_valid rises.
// After rst_n the memory is cleared to the basis state zero by a pass over
// every address during which in_ready stays low; the reset command runs the same pass.
// Results wait in an output register; while the receiver stalls, the block
// still accepts the next item and finishes it, then holds until the register
// is free.
`default_nettype none
module qubit_state_vector_gate_apply_unit #(
  parameter int QUBITS = 10
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qsv_in_if.sink    in_if,
  qsv_out_if.source out_if
);
  import qsv_pkg::*;

  op_t               in_op, op;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [QUBITS-1:0] cnt;
  logic              ready_w, valid_w;

  assign in_op.cmd       = in_if.command;
  assign in_op.gate      = in_if.gate_code;
  assign in_op.qa        = in_if.qubit_a;
  assign in_op.qb        = in_if.qubit_b;
  assign in_op.amp_index = in_if.amp_index;
  assign in_if.ready     = ready_w;
  assign out_if.valid    = valid_w;

  qsv_ctrl #(.QUBITS(QUBITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (ready_w),
    .in_op     (in_op),
    .out_valid (valid_w),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .op        (op),
    .cnt       (cnt),
    .stat      (stat)
  );

  qsv_datapath #(.QUBITS(QUBITS)) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .op         (op),
    .cnt        (cnt),
    .stat       (stat),
    .amp_real   (out_if.amp_real),
    .amp_imag   (out_if.amp_imag),
    .error_flag (out_if.error_flag)
  );

endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for the state-vector gate engine: directed and random commands,
// checked against an in-bench amplitude predictor. Depends on qsv_pkg,
// qsv_in_if/qsv_out_if and qubit_state_vector_gate_apply_unit.
`timescale 1ns / 100ps
module tb;
  import qsv_pkg::*;

  localparam int QUBITS    = 10;
  localparam int AMP_COUNT = 1 << QUBITS;
  localparam int LIMIT     = 20000000;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               err;
  } amp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qsv_in_if  in_if ();
  qsv_out_if out_if ();

  qubit_state_vector_gate_apply_unit #(.QUBITS(QUBITS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gate entries in row-major order: r0c0, r0c1, r1c0, r1c1
  int gate_re [16][4] = '{
    '{16384, 0, 0, 16384}, '{0, 16384, 16384, 0}, '{0, 0, 0, 0},
    '{16384, 0, 0, -16384}, '{11585, 11585, 11585, -11585}, '{0, 11585, 11585, 0},
    '{11585, 11585, 11585, -11585}, '{11585, 0, 0, -11585},
    '{8192, 8192, 8192, 8192}, '{8192, 8192, 8192, 8192},
    '{8192, -8192, 8192, 8192}, '{8192, 8192, -8192, 8192},
    '{16384, 0, 0, 0}, '{16384, 0, 0, 0}, '{16384, 0, 0, 0}, '{16384, 0, 0, 0}};
  int gate_im [16][4] = '{
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, -16384, 16384, 0}, '{0, 0, 0, 0},
    '{0, 0, 0, 0}, '{0, -11585, 11585, 0}, '{0, 0, 0, 0}, '{0, -11585, 11585, 0},
    '{8192, -8192, -8192, 8192}, '{-8192, 8192, 8192, -8192},
    '{8192, -8192, 8192, 8192}, '{-8192, -8192, 8192, -8192},
    '{0, 0, 0, 16384}, '{0, 0, 0, -16384}, '{0, 0, 0, 16384}, '{0, 0, 0, -16384}};

  int amp_re [AMP_COUNT];
  int amp_im [AMP_COUNT];
  amp_result_t pending_amps[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  rx_hold_cycles = 0;
  bit  calm = 1'b0;

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int round_q14_nearest(longint s);
    longint mag, q;
    mag = (s < 0) ? -s : s;
    q = (mag + 8192) >>> 14;
    return sat16((s < 0) ? -q : q);
  endfunction

  function automatic void clear_amps();
    foreach (amp_re[k]) begin
      amp_re[k] = 0;
      amp_im[k] = 0;
    end
    amp_re[0] = 16384;
  endfunction

  function automatic void rotate_pairs(int g, int q);
    longint xr[2], xi[2], sr, si;
    int idx[2];
    for (int base = 0; base < AMP_COUNT; base++) begin
      if (base & (1 << q)) continue;
      idx[0] = base;
      idx[1] = base | (1 << q);
      for (int c = 0; c < 2; c++) begin
        xr[c] = amp_re[idx[c]];
        xi[c] = amp_im[idx[c]];
      end
      for (int r = 0; r < 2; r++) begin
        sr = 0;
        si = 0;
        for (int c = 0; c < 2; c++) begin
          sr += gate_re[g][r*2+c] * xr[c] - gate_im[g][r*2+c] * xi[c];
          si += gate_re[g][r*2+c] * xi[c] + gate_im[g][r*2+c] * xr[c];
        end
        amp_re[idx[r]] = round_q14_nearest(sr);
        amp_im[idx[r]] = round_q14_nearest(si);
      end
    end
  endfunction

  function automatic void exchange_amps(int i, int j);
    int t;
    t = amp_re[i]; amp_re[i] = amp_re[j]; amp_re[j] = t;
    t = amp_im[i]; amp_im[i] = amp_im[j]; amp_im[j] = t;
  endfunction

  function automatic void entangle_quads(logic [3:0] g, int qa, int qb);
    int ba, bb;
    ba = 1 << qa;
    bb = 1 << qb;
    for (int base = 0; base < AMP_COUNT; base++) begin
      if (base & (ba | bb)) continue;
      if (g == G2_CNOT) begin
        exchange_amps(base | ba, base | ba | bb);
      end else if (g == G2_CZ) begin
        amp_re[base | ba | bb] = sat16(-longint'(amp_re[base | ba | bb]));
        amp_im[base | ba | bb] = sat16(-longint'(amp_im[base | ba | bb]));
      end else begin
        exchange_amps(base | ba, base | bb);
      end
    end
  endfunction

  function automatic void predict_amp(logic [1:0] cmd, logic [3:0] g, logic [3:0] qa,
                                      logic [3:0] qb, logic [9:0] idx);
    amp_result_t r;
    r.re = '0;
    r.im = '0;
    r.err = 1'b0;
    case (cmd)
      CMD_G1: begin
        if (qa >= QUBITS) r.err = 1'b1;
        else rotate_pairs(g, qa);
      end
      CMD_G2: begin
        if (qa >= QUBITS || qb >= QUBITS || qa == qb || g > G2_SWAP) r.err = 1'b1;
        else entangle_quads(g, qa, qb);
      end
      CMD_RD: begin
        if (idx >= AMP_COUNT) begin
          r.err = 1'b1;
        end else begin
          r.re = 16'(amp_re[idx]);
          r.im = 16'(amp_im[idx]);
        end
      end
      default: clear_amps();
    endcase
    pending_amps.insert(pending_amps.size(), r);
  endfunction

  // Leave valid high after acceptance; a gap drops it before the next item.
  task automatic send_cmd(logic [1:0] cmd, logic [3:0] g, logic [3:0] qa,
                          logic [3:0] qb, logic [9:0] idx);
    if (!calm && $urandom_range(99) < 21) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.gate_code <= g;
    in_if.qubit_a   <= qa;
    in_if.qubit_b   <= qb;
    in_if.amp_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    predict_amp(cmd, g, qa, qb, idx);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_amps.size() != 0) @(posedge clk);
  endtask

  task automatic read_amp(logic [9:0] idx);
    send_cmd(CMD_RD, 4'($urandom), 4'($urandom), 4'($urandom), idx);
  endtask

  task automatic test_reset_state();
    read_amp(10'd0);
    read_amp(10'd1);
    read_amp(10'd1023);
  endtask

  task automatic test_one_qubit_gates();
    for (int g = 0; g < 16; g++) send_cmd(CMD_G1, 4'(g), 4'(g % QUBITS), 4'd15, 10'd0);
    send_cmd(CMD_G1, 4'd4, 4'd15, 4'd0, 10'd0);
    send_cmd(CMD_G1, 4'd4, 4'd10, 4'd0, 10'd0);
    read_amp(10'd0);
    read_amp(10'd513);
  endtask

  task automatic test_two_qubit_gates();
    send_cmd(CMD_G2, G2_CNOT, 4'd0, 4'd9, 10'd0);
    send_cmd(CMD_G2, G2_CZ, 4'd9, 4'd1, 10'd0);
    send_cmd(CMD_G2, G2_SWAP, 4'd2, 4'd0, 10'd0);
    send_cmd(CMD_G2, G2_CNOT, 4'd3, 4'd3, 10'd0);
    send_cmd(CMD_G2, G2_SWAP, 4'd15, 4'd1, 10'd0);
    send_cmd(CMD_G2, 4'd15, 4'd1, 4'd2, 10'd0);
    read_amp(10'd1023);
    send_cmd(CMD_RST, 4'd15, 4'd15, 4'd15, 10'd1023);
    read_amp(10'd0);
  endtask

  task automatic test_random_mix(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 3 && n < count / 3 + 40);
      pick = $urandom_range(99);
      if (pick < 15)
        send_cmd(CMD_G1, 4'($urandom), 4'($urandom_range(99) < 85 ?
                 $urandom_range(QUBITS - 1) : $urandom_range(15)), 4'($urandom), 10'($urandom));
      else if (pick < 25)
        send_cmd(CMD_G2, 4'($urandom_range(99) < 85 ? $urandom_range(2) : $urandom_range(15)),
                 4'($urandom_range(QUBITS - 1)), 4'($urandom_range(99) < 85 ?
                 $urandom_range(QUBITS - 1) : $urandom_range(15)), 10'($urandom));
      else if (pick < 28)
        send_cmd(CMD_RST, 4'($urandom), 4'($urandom), 4'($urandom), 10'($urandom));
      else
        read_amp(10'($urandom));
    end
    calm = 1'b0;
  endtask

  // Stall the receiver long enough for the block to back up onto its input.
  task automatic test_backpressure();
    @(posedge clk);
    rx_hold_cycles <= 400;
    for (int n = 0; n < 8; n++) read_amp(10'($urandom));
    send_cmd(CMD_G1, 4'd4, 4'd0, 4'd0, 10'd0);
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rx_hold_cycles != 0) rx_hold_cycles <= rx_hold_cycles - 1;
    out_if.ready <= rst_n && rx_hold_cycles == 0 && (calm || $urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    amp_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_amps.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        want = pending_amps.pop_front();
        if (out_if.amp_real !== want.re) begin
          $error("amp_real expected %0d got %0d", want.re, out_if.amp_real);
          fail_count++;
        end
        if (out_if.amp_imag !== want.im) begin
          $error("amp_imag expected %0d got %0d", want.im, out_if.amp_imag);
          fail_count++;
        end
        if (out_if.error_flag !== want.err) begin
          $error("error_flag expected %0d got %0d", want.err, out_if.error_flag);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.command   = CMD_RD;
    in_if.gate_code = '0;
    in_if.qubit_a   = '0;
    in_if.qubit_b   = '0;
    in_if.amp_index = '0;
    out_if.ready    = 1'b0;
    clear_amps();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_one_qubit_gates();
    test_two_qubit_gates();
    drain_results();
    // spread the state before random traffic
    for (int q = 0; q < 4; q++) send_cmd(CMD_G1, 4'd4, 4'(q * 2), 4'd0, 10'd0);
    test_backpressure();
    test_random_mix(420);
    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
